### rtl/wtosc_pkg.sv
// Shared types, constants and waveform helper functions for the wavetable oscillator.
package wtosc_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  // Field widths and fixed point formats
  localparam int FRAC_BITS  = 21;
  localparam int INC_W      = 32;
  localparam int LEN_W      = 24;
  localparam int DECAY_W    = 32;
  localparam int ENV_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_NOTE_LEN  = 2'd1,
    CFG_DECAY     = 2'd2
  } cfg_idx_t;

  // Register reset values
  localparam logic [INC_W-1:0]   PHASE_INC_RST = 32'd42852790;
  localparam logic [LEN_W-1:0]   NOTE_LEN_RST  = 24'd44100;
  localparam logic [DECAY_W-1:0] DECAY_RST     = 32'd4294772522;

  // Envelope unity in Q1.31
  localparam logic [ENV_W-1:0] ENV_ONE = 32'h8000_0000;

  // Harmonic content of the waveform (amplitudes in Q0.20)
  localparam int NUM_HARM = 7;
  localparam longint HARM_MULT [NUM_HARM] = '{1, 2, 3, 4, 6, 7, 8};
  localparam longint HARM_AMP  [NUM_HARM] = '{68157, 32506, 18350, 6291, 881, 3146, 797};

  localparam longint Q30_ONE = 64'sd1 <<< 30;

  // Sine of t turns (t in Q0.32), Q30 result; odd degree-9 polynomial per quarter wave
  function automatic longint sine_q30(input logic [31:0] t);
    logic [1:0] quad;
    longint     u;
    longint     u2;
    longint     p;
    longint     r;
    quad = t[31:30];
    u    = longint'({34'd0, t[29:0]});
    if (quad[0]) begin
      u = Q30_ONE - u;
    end
    u2 = (u * u) >>> 30;
    p  = 64'sd172272;
    p  = -64'sd5026990 + p * u2 / Q30_ONE;
    p  = 64'sd85569613 + p * u2 / Q30_ONE;
    p  = -64'sd693598288 + p * u2 / Q30_ONE;
    p  = 64'sd1686629713 + p * u2 / Q30_ONE;
    r  = p * u / Q30_ONE;
    return quad[1] ? -r : r;
  endfunction

endpackage

### rtl/wtosc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wtosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wavetable_oscillator_with_decay_top.sv
// Path: an accepted request is registered in stage 1 (RAM read) and then in the stage 2 output
//   register, where its sample shows. Throughput: one request per cycle while in_stall is low;
//   the waveform RAM read and the envelope multiply each take one stage.
// Reset (synchronous, rst_n low): registers take their defaults, voice idle, then the
//   waveform RAM is loaded entry by entry, with in_stall high until it is done.
module wavetable_oscillator_with_decay_top #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wtosc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wtosc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // tick requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  // samples
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic                              out_last
);

  import wtosc_pkg::*;

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int PHASE_W   = ADDR_W + FRAC_BITS;
  localparam int RED_W     = (PHASE_W + 2 > INC_W) ? PHASE_W + 2 : INC_W;
  localparam int RED_STEPS = 3;
  localparam int PROD_W    = SAMPLE_BITS - 1 + ENV_W;

  localparam logic [PHASE_W:0] WRAP_V =
    (PHASE_W+1)'(longint'(TABLE_DEPTH) <<< FRAC_BITS);
  localparam logic [PHASE_W-1:0] INC_MOD_RST =
    PHASE_W'(longint'(PHASE_INC_RST) % (longint'(TABLE_DEPTH) <<< FRAC_BITS));
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ENV_W - 2);
  localparam longint SAMPLE_FULL = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;

  // ---------------------------------------------------------------------------
  // Waveform image, built at elaboration
  // ---------------------------------------------------------------------------
  typedef logic [SAMPLE_BITS-1:0] rom_img_t [TABLE_DEPTH];

  // Harmonic sum of one entry, Q40
  function automatic longint rom_raw(input int i);
    longint      s;
    longint      m;
    logic [31:0] t;
    s = 0;
    for (int k = 0; k < NUM_HARM; k++) begin
      m = (HARM_MULT[k] * longint'(i)) % TABLE_DEPTH;
      t = 32'((m <<< 32) / TABLE_DEPTH);
      s = s + HARM_AMP[k] * sine_q30(t) / 1024;
    end
    return s;
  endfunction

  // Positive peak of the harmonic sum
  function automatic longint rom_peak();
    longint pk;
    longint s;
    pk = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      s = rom_raw(i);
      if (s > pk) begin
        pk = s;
      end
    end
    return pk;
  endfunction

  localparam longint ROM_PEAK = rom_peak();

  // Scale so the positive peak hits full scale, round half away from zero
  function automatic rom_img_t build_rom();
    rom_img_t img;
    longint   s;
    longint   mag;
    longint   r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ROM_PEAK <= 0) begin
        img[i] = '0;
      end else begin
        s   = rom_raw(i);
        mag = (s < 0) ? -s : s;
        r   = (mag * SAMPLE_FULL + ROM_PEAK / 2) / ROM_PEAK;
        if (r > SAMPLE_FULL) begin
          r = SAMPLE_FULL;
        end
        img[i] = SAMPLE_BITS'((s < 0) ? -r : r);
      end
    end
    return img;
  endfunction

  localparam rom_img_t ROM_IMG = build_rom();

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic                    fill_busy_r;
  logic [ADDR_W-1:0]       fill_cnt_r;

  logic [PHASE_W-1:0]      inc_mod_r, inc_mod_nxt;
  logic                    inc_nz_r;
  logic [LEN_W-1:0]        note_len_r;
  logic [DECAY_W-1:0]      decay_r;
  logic [RED_W-1:0]        inc_red;

  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic [ENV_W-1:0]        env_r, env_nxt;
  logic [LEN_W-1:0]        samples_left_r, samples_left_nxt;

  logic                    accept;
  logic                    start_ok;
  logic                    emit;
  logic [LEN_W-1:0]        left_use;
  logic [PHASE_W-1:0]      phase_use;
  logic [ENV_W-1:0]        env_use;
  logic [PHASE_W:0]        phase_sum;
  logic [PHASE_W-1:0]      phase_wrapped;
  logic [2*ENV_W-1:0]      env_prod;
  logic [2*ENV_W-1:0]      env_rnd;
  logic [ADDR_W-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0]  rom_data;

  logic                    s1_valid_r;
  logic [ENV_W-1:0]        s1_env_r;
  logic                    s1_last_r;
  logic                    s1_ready;

  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_sample_r, out_sample_nxt;
  logic                    out_last_r;
  logic                    out_ready;

  logic                    rom_neg;
  logic [SAMPLE_BITS-1:0]  mag_full;
  logic [PROD_W-1:0]       amp_prod;
  logic [PROD_W-1:0]       amp_rnd;
  logic [SAMPLE_BITS-2:0]  amp_mag;

  // ---------------------------------------------------------------------------
  // Waveform RAM, loaded after reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (fill_busy_r) begin
      if (fill_cnt_r == ADDR_W'(TABLE_DEPTH - 1)) begin
        fill_busy_r <= 1'b0;
      end else begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  wtosc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_wave_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_cnt_r),
    .wdata (ROM_IMG[fill_cnt_r]),
    .re    (accept && emit),
    .raddr (rd_addr),
    .rdata (rom_data)
  );

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  // Increment reduced modulo the wrap length; the reduction holds for a quotient of at most seven
  always_comb begin
    inc_red = RED_W'(cfg_wdata[INC_W-1:0]);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (inc_red >= (RED_W'(WRAP_V) << k)) begin
        inc_red = inc_red - (RED_W'(WRAP_V) << k);
      end
    end
    inc_mod_nxt = inc_red[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_mod_r  <= INC_MOD_RST;
      inc_nz_r   <= (PHASE_INC_RST != '0);
      note_len_r <= NOTE_LEN_RST;
      decay_r    <= DECAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PHASE_INC: begin
          inc_mod_r <= inc_mod_nxt;
          inc_nz_r  <= (cfg_wdata[INC_W-1:0] != '0);
        end
        CFG_NOTE_LEN: begin
          note_len_r <= cfg_wdata[LEN_W-1:0];
        end
        CFG_DECAY: begin
          decay_r <= cfg_wdata[DECAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Voice state: phase, envelope and sample count
  // ---------------------------------------------------------------------------
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = fill_busy_r || !s1_ready;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    start_ok  = inc_nz_r && (note_len_r != '0);
    left_use  = in_restart ? (start_ok ? note_len_r : '0) : samples_left_r;
    phase_use = in_restart ? '0 : phase_r;
    env_use   = in_restart ? ENV_ONE : env_r;
    emit      = (left_use != '0);
    rd_addr   = phase_use[PHASE_W-1:FRAC_BITS];

    // phase advance with wrap
    phase_sum = {1'b0, phase_use} + {1'b0, inc_mod_r};
    if (phase_sum >= WRAP_V) begin
      phase_sum = phase_sum - WRAP_V;
    end
    phase_wrapped = phase_sum[PHASE_W-1:0];

    // envelope decay, rounded
    env_prod = {{ENV_W{1'b0}}, env_use} * {{(2*ENV_W-DECAY_W){1'b0}}, decay_r};
    env_rnd  = env_prod + {{ENV_W{1'b0}}, ENV_ONE};

    phase_nxt        = phase_r;
    env_nxt          = env_r;
    samples_left_nxt = samples_left_r;
    if (accept) begin
      samples_left_nxt = left_use;
      if (emit) begin
        samples_left_nxt = left_use - 1'b1;
        phase_nxt        = phase_wrapped;
        env_nxt          = env_rnd[2*ENV_W-1:ENV_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= '0;
      env_r          <= ENV_ONE;
      samples_left_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      env_r          <= env_nxt;
      samples_left_r <= samples_left_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: RAM read in flight, envelope and last flag alongside
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_env_r  <= env_use;
      s1_last_r <= (left_use == LEN_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sign-magnitude scale by envelope, round to nearest
  // ---------------------------------------------------------------------------
  always_comb begin
    rom_neg  = rom_data[SAMPLE_BITS-1];
    mag_full = rom_neg ? (~rom_data + 1'b1) : rom_data;
    amp_prod = {{ENV_W{1'b0}}, mag_full[SAMPLE_BITS-2:0]} * {{(PROD_W-ENV_W){1'b0}}, s1_env_r};
    amp_rnd  = amp_prod + ROUND_HALF;
    amp_mag  = amp_rnd[ENV_W-1 +: SAMPLE_BITS-1];
    out_sample_nxt = rom_neg ? (~{1'b0, amp_mag} + 1'b1) : {1'b0, amp_mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_sample_r <= out_sample_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // no request taken while the waveform RAM is still loading
  a_fill_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy_r |-> in_stall)
    else $error("request accepted during waveform load");

  // envelope never grows past unity
  a_env_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ENV_ONE)
    else $error("envelope above 1.0");

  // phase stays inside one table period
  a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, phase_r} < WRAP_V)
    else $error("phase outside table period");

  // a valid note start loads the length and spends its first sample
  a_note_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart && inc_nz_r && (note_len_r != '0)) |=>
      (samples_left_r == $past(note_len_r) - 1'b1) && (env_r <= ENV_ONE))
    else $error("note start did not load the sample count");
`endif

endmodule
